>>> rtl/least_squares_line_fit_unit_macros.svh
// Assertion macros shared by the line fit unit
`ifndef LEAST_SQUARES_LINE_FIT_UNIT_MACROS_SVH
`define LEAST_SQUARES_LINE_FIT_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define LSF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("line fit unit: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define LSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("line fit unit: next-cycle check failed");

`endif

>>> rtl/lsf_pkg.sv
// Package: types, constants and the solve program of the line fit unit
`timescale 1ns / 1ps
`default_nettype none
package lsf_pkg;

	localparam int XY_W            = 16;
	localparam int OUT_W           = 32;
	localparam int R2_W            = 17;
	localparam int STATUS_W        = 2;
	localparam int Q_FRAC          = 16;
	localparam int R2_ONE          = 65536;
	localparam int DEF_MAX_SAMPLES = 128;
	localparam int DEF_SAMPLE_BITS = 16;
	localparam int NUM_STEPS       = 20;
	localparam int PC_W            = 5;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_X_CONST  = 2'd1,
		STAT_Y_CONST  = 2'd2,
		STAT_OVERFLOW = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_SUB,
		OP_DIV
	} op_t;

	typedef enum logic [3:0] {
		SRC_N,
		SRC_SX,
		SRC_SY,
		SRC_SXX,
		SRC_SYY,
		SRC_SXY,
		SRC_T0,
		SRC_T1,
		SRC_CXX,
		SRC_CYY,
		SRC_CXY
	} src_t;

	typedef enum logic [3:0] {
		DST_T0,
		DST_T1,
		DST_CXX,
		DST_CYY,
		DST_CXY,
		DST_MX,
		DST_MY,
		DST_SLOPE,
		DST_ICPT,
		DST_R2
	} dst_t;

	typedef enum logic [1:0] {
		CND_ALWAYS,
		CND_X_VAR,
		CND_XY_VAR
	} cond_t;

	typedef struct packed {
		op_t   op;
		src_t  a;
		src_t  b;
		dst_t  d;
		cond_t cond;
	} step_t;

	typedef enum logic [2:0] {
		CS_ACCUM,
		CS_FLUSH,
		CS_ISSUE,
		CS_WAIT,
		CS_DONE
	} ctl_state_t;

	typedef struct packed {
		logic  accum;
		logic  start_op;
		step_t step;
		logic  load_out;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic cxx_zero;
		logic cyy_zero;
	} stat_t;

	// solve program: covariances, means, slope, intercept, r squared
	function automatic step_t prog_step(input logic [PC_W-1:0] pc);
		step_t s;
		case (pc)
			5'd0:    s = '{OP_MUL, SRC_N,   SRC_SXX, DST_T0,    CND_ALWAYS};
			5'd1:    s = '{OP_MUL, SRC_SX,  SRC_SX,  DST_T1,    CND_ALWAYS};
			5'd2:    s = '{OP_SUB, SRC_T0,  SRC_T1,  DST_CXX,   CND_ALWAYS};
			5'd3:    s = '{OP_MUL, SRC_N,   SRC_SYY, DST_T0,    CND_ALWAYS};
			5'd4:    s = '{OP_MUL, SRC_SY,  SRC_SY,  DST_T1,    CND_ALWAYS};
			5'd5:    s = '{OP_SUB, SRC_T0,  SRC_T1,  DST_CYY,   CND_ALWAYS};
			5'd6:    s = '{OP_MUL, SRC_N,   SRC_SXY, DST_T0,    CND_ALWAYS};
			5'd7:    s = '{OP_MUL, SRC_SX,  SRC_SY,  DST_T1,    CND_ALWAYS};
			5'd8:    s = '{OP_SUB, SRC_T0,  SRC_T1,  DST_CXY,   CND_ALWAYS};
			5'd9:    s = '{OP_DIV, SRC_SX,  SRC_N,   DST_MX,    CND_ALWAYS};
			5'd10:   s = '{OP_DIV, SRC_SY,  SRC_N,   DST_MY,    CND_ALWAYS};
			5'd11:   s = '{OP_DIV, SRC_CXY, SRC_CXX, DST_SLOPE, CND_X_VAR};
			5'd12:   s = '{OP_MUL, SRC_SY,  SRC_CXX, DST_T0,    CND_X_VAR};
			5'd13:   s = '{OP_MUL, SRC_SX,  SRC_CXY, DST_T1,    CND_X_VAR};
			5'd14:   s = '{OP_SUB, SRC_T0,  SRC_T1,  DST_T0,    CND_X_VAR};
			5'd15:   s = '{OP_MUL, SRC_N,   SRC_CXX, DST_T1,    CND_X_VAR};
			5'd16:   s = '{OP_DIV, SRC_T0,  SRC_T1,  DST_ICPT,  CND_X_VAR};
			5'd17:   s = '{OP_MUL, SRC_CXY, SRC_CXY, DST_T0,    CND_XY_VAR};
			5'd18:   s = '{OP_MUL, SRC_CXX, SRC_CYY, DST_T1,    CND_XY_VAR};
			5'd19:   s = '{OP_DIV, SRC_T0,  SRC_T1,  DST_R2,    CND_XY_VAR};
			default: s = '{OP_SUB, SRC_T0,  SRC_T0,  DST_T0,    CND_ALWAYS};
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

>>> rtl/lsf_if.sv
// Channel interfaces: sample pairs in, fit results out
`timescale 1ns / 1ps
`default_nettype none
interface lsf_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [lsf_pkg::XY_W-1:0]   x_value;
	logic signed [lsf_pkg::XY_W-1:0]   y_value;
	logic                              last;

	modport source (output valid, output x_value, output y_value, output last, input ready);
	modport sink   (input valid, input x_value, input y_value, input last, output ready);
endinterface

interface lsf_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [lsf_pkg::OUT_W-1:0]    mean_x;
	logic signed [lsf_pkg::OUT_W-1:0]    mean_y;
	logic signed [lsf_pkg::OUT_W-1:0]    slope;
	logic signed [lsf_pkg::OUT_W-1:0]    intercept;
	logic        [lsf_pkg::R2_W-1:0]     r_squared;
	logic        [lsf_pkg::STATUS_W-1:0] status;

	modport source (output valid, output mean_x, output mean_y, output slope,
		output intercept, output r_squared, output status, input ready);
	modport sink   (input valid, input mean_x, input mean_y, input slope,
		input intercept, input r_squared, input status, output ready);
endinterface
`default_nettype wire

>>> rtl/lsf_datapath.sv
// Datapath: running sums, serial multiply/divide unit, work and output registers
`timescale 1ns / 1ps
`default_nettype none
module lsf_datapath #(
	parameter int MAX_SAMPLES = lsf_pkg::DEF_MAX_SAMPLES,
	parameter int SAMPLE_BITS = lsf_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [lsf_pkg::XY_W-1:0]     x_value,
	input  logic signed [lsf_pkg::XY_W-1:0]     y_value,
	input  lsf_pkg::cmd_t                       cmd,
	output lsf_pkg::stat_t                      stat,
	output logic signed [lsf_pkg::OUT_W-1:0]    mean_x,
	output logic signed [lsf_pkg::OUT_W-1:0]    mean_y,
	output logic signed [lsf_pkg::OUT_W-1:0]    slope,
	output logic signed [lsf_pkg::OUT_W-1:0]    intercept,
	output logic        [lsf_pkg::R2_W-1:0]     r_squared,
	output logic        [lsf_pkg::STATUS_W-1:0] status
);
	import lsf_pkg::*;

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int SX_W  = SAMPLE_BITS + CNT_W;
	localparam int SQ_W  = 2 * SAMPLE_BITS + CNT_W;
	localparam int C_W   = 2 * SAMPLE_BITS + 2 * CNT_W + 1;
	localparam int BW    = 2 * C_W + Q_FRAC + 2;
	localparam int IT_W  = $clog2(BW + 1);

	// sample extraction: low SAMPLE_BITS of the field as two's complement
	logic signed [SAMPLE_BITS-1:0] xs, ys;
	always_comb begin
		for (int i = 0; i < SAMPLE_BITS; i++) begin
			xs[i] = (i < XY_W) ? x_value[i % XY_W] : 1'b0;
			ys[i] = (i < XY_W) ? y_value[i % XY_W] : 1'b0;
		end
	end

	// product stage
	logic signed [SAMPLE_BITS-1:0]   x_s1, y_s1;
	logic signed [2*SAMPLE_BITS-1:0] xx_s1, yy_s1, xy_s1;
	logic                            valid_s1;

	always_ff @(posedge clk) begin
		if (cmd.accum) begin
			x_s1  <= xs;
			y_s1  <= ys;
			xx_s1 <= xs * xs;
			yy_s1 <= ys * ys;
			xy_s1 <= xs * ys;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.accum;
		end
	end

	// running sums
	logic [CNT_W-1:0]       cnt_q;
	logic signed [SX_W-1:0] sx_q, sy_q;
	logic signed [SQ_W-1:0] sxx_q, syy_q, sxy_q;
	logic                   ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
			sxx_q <= '0;
			syy_q <= '0;
			sxy_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.load_out) begin
			cnt_q <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
			sxx_q <= '0;
			syy_q <= '0;
			sxy_q <= '0;
			ovf_q <= 1'b0;
		end else if (valid_s1) begin
			if (cnt_q < CNT_W'(MAX_SAMPLES)) begin
				cnt_q <= cnt_q + 1'b1;
				sx_q  <= sx_q + SX_W'(x_s1);
				sy_q  <= sy_q + SX_W'(y_s1);
				sxx_q <= sxx_q + SQ_W'(xx_s1);
				syy_q <= syy_q + SQ_W'(yy_s1);
				sxy_q <= sxy_q + SQ_W'(xy_s1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// work registers
	logic signed [BW-1:0]    t0_q, t1_q, cxx_q, cyy_q, cxy_q;
	logic signed [OUT_W-1:0] mx_q, my_q, slope_q, icpt_q;
	logic [R2_W-1:0]         r2_q;

	// operand select
	logic signed [BW-1:0] opa, opb;
	always_comb begin
		case (cmd.step.a)
			SRC_N:   opa = BW'(cnt_q);
			SRC_SX:  opa = BW'(sx_q);
			SRC_SY:  opa = BW'(sy_q);
			SRC_SXX: opa = BW'(sxx_q);
			SRC_SYY: opa = BW'(syy_q);
			SRC_SXY: opa = BW'(sxy_q);
			SRC_T0:  opa = t0_q;
			SRC_T1:  opa = t1_q;
			SRC_CXX: opa = cxx_q;
			SRC_CYY: opa = cyy_q;
			SRC_CXY: opa = cxy_q;
			default: opa = '0;
		endcase
		case (cmd.step.b)
			SRC_N:   opb = BW'(cnt_q);
			SRC_SX:  opb = BW'(sx_q);
			SRC_SY:  opb = BW'(sy_q);
			SRC_SXX: opb = BW'(sxx_q);
			SRC_SYY: opb = BW'(syy_q);
			SRC_SXY: opb = BW'(sxy_q);
			SRC_T0:  opb = t0_q;
			SRC_T1:  opb = t1_q;
			SRC_CXX: opb = cxx_q;
			SRC_CYY: opb = cyy_q;
			SRC_CXY: opb = cxy_q;
			default: opb = '0;
		endcase
	end

	logic [BW-1:0] mag_a, mag_b;
	assign mag_a = opa[BW-1] ? BW'(-opa) : BW'(opa);
	assign mag_b = opb[BW-1] ? BW'(-opb) : BW'(opb);

	// shared serial unit: shift-add multiply, restoring divide
	logic            busy_q, neg_q;
	op_t             op_q;
	dst_t            dst_q;
	logic [BW-1:0]   acc_q, mcand_q, mplier_q;
	logic [IT_W-1:0] it_q;
	logic [BW-1:0]   rem_sh;
	logic            rem_ge;

	assign rem_sh = {acc_q[BW-2:0], mplier_q[BW-1]};
	assign rem_ge = (rem_sh >= mcand_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (cmd.start_op && cmd.step.op != OP_SUB) begin
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (op_q == OP_DIV) begin
				if (it_q == '0) begin
					busy_q <= 1'b0;
				end
			end else if (mplier_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_op) begin
			op_q   <= cmd.step.op;
			dst_q  <= cmd.step.d;
			neg_q  <= opa[BW-1] ^ opb[BW-1];
			acc_q  <= '0;
			it_q   <= IT_W'(BW);
			if (cmd.step.op == OP_DIV) begin
				mplier_q <= mag_a << Q_FRAC;
				mcand_q  <= mag_b;
			end else begin
				mplier_q <= mag_b;
				mcand_q  <= mag_a;
			end
		end else if (busy_q) begin
			if (op_q == OP_DIV) begin
				if (it_q != '0) begin
					acc_q    <= rem_ge ? rem_sh - mcand_q : rem_sh;
					mplier_q <= {mplier_q[BW-2:0], rem_ge};
					it_q     <= it_q - 1'b1;
				end
			end else if (mplier_q != '0) begin
				acc_q    <= acc_q + (mplier_q[0] ? mcand_q : '0);
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
			end
		end
	end

	// write-back
	logic                    wr_en;
	dst_t                    wr_dst;
	logic signed [BW-1:0]    wr_full;
	logic [BW-1:0]           q_lim, q_sat;
	logic signed [OUT_W-1:0] wr_sat;
	logic [R2_W-1:0]         wr_r2;

	always_comb begin
		wr_en   = 1'b0;
		wr_dst  = dst_q;
		wr_full = neg_q ? -$signed(acc_q) : $signed(acc_q);
		if (cmd.start_op && cmd.step.op == OP_SUB) begin
			wr_en   = 1'b1;
			wr_dst  = cmd.step.d;
			wr_full = opa - opb;
		end else if (busy_q && op_q == OP_DIV) begin
			wr_en   = (it_q == '0);
			wr_full = neg_q ? -$signed(mplier_q) : $signed(mplier_q);
		end else if (busy_q) begin
			wr_en   = (mplier_q == '0);
		end
		q_lim  = neg_q ? BW'(64'h8000_0000) : BW'(64'h7FFF_FFFF);
		q_sat  = (mplier_q > q_lim) ? q_lim : mplier_q;
		wr_sat = neg_q ? -$signed(q_sat[OUT_W-1:0]) : $signed(q_sat[OUT_W-1:0]);
		wr_r2  = (mplier_q > BW'(R2_ONE)) ? R2_W'(R2_ONE) : mplier_q[R2_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			case (wr_dst)
				DST_T0:    t0_q    <= wr_full;
				DST_T1:    t1_q    <= wr_full;
				DST_CXX:   cxx_q   <= wr_full;
				DST_CYY:   cyy_q   <= wr_full;
				DST_CXY:   cxy_q   <= wr_full;
				DST_MX:    mx_q    <= wr_sat;
				DST_MY:    my_q    <= wr_sat;
				DST_SLOPE: slope_q <= wr_sat;
				DST_ICPT:  icpt_q  <= wr_sat;
				DST_R2:    r2_q    <= wr_r2;
				default:   t0_q    <= wr_full;
			endcase
		end
	end

	assign stat.busy     = busy_q;
	assign stat.cxx_zero = (cxx_q == '0);
	assign stat.cyy_zero = (cyy_q == '0);

	// output register: special cases folded in at load
	logic signed [OUT_W-1:0]  mean_x_q, mean_y_q, slope_q2, intercept_q;
	logic [R2_W-1:0]          r_squared_q;
	status_t                  status_q;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			mean_x_q    <= mx_q;
			mean_y_q    <= my_q;
			slope_q2    <= stat.cxx_zero ? '0 : slope_q;
			intercept_q <= stat.cxx_zero ? my_q : icpt_q;
			r_squared_q <= (stat.cxx_zero || stat.cyy_zero) ? '0 : r2_q;
			if (ovf_q) begin
				status_q <= STAT_OVERFLOW;
			end else if (stat.cxx_zero) begin
				status_q <= STAT_X_CONST;
			end else if (stat.cyy_zero) begin
				status_q <= STAT_Y_CONST;
			end else begin
				status_q <= STAT_OK;
			end
		end
	end

	assign mean_x    = mean_x_q;
	assign mean_y    = mean_y_q;
	assign slope     = slope_q2;
	assign intercept = intercept_q;
	assign r_squared = r_squared_q;
	assign status    = status_q;
endmodule
`default_nettype wire

>>> rtl/lsf_controller.sv
// Controller: accept pairs, step through the solve program, hand over results
`timescale 1ns / 1ps
`default_nettype none
module lsf_controller (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_last,
	output logic            in_ready,
	input  logic            out_ready,
	output logic            out_valid,
	output lsf_pkg::cmd_t   cmd,
	input  lsf_pkg::stat_t  stat
);
	import lsf_pkg::*;

	ctl_state_t       state_q, state_d;
	logic [PC_W-1:0]  pc_q, pc_d;
	logic             out_valid_q;
	logic             cond_ok;
	logic             last_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_ACCUM;
			pc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign last_step = (pc_q == PC_W'(NUM_STEPS - 1));

	always_comb begin
		state_d      = state_q;
		pc_d         = pc_q;
		in_ready     = 1'b0;
		cmd.accum    = 1'b0;
		cmd.start_op = 1'b0;
		cmd.load_out = 1'b0;
		cmd.step     = prog_step(pc_q);
		case (cmd.step.cond)
			CND_ALWAYS: cond_ok = 1'b1;
			CND_X_VAR:  cond_ok = !stat.cxx_zero;
			CND_XY_VAR: cond_ok = !stat.cxx_zero && !stat.cyy_zero;
			default:    cond_ok = 1'b1;
		endcase
		case (state_q)
			CS_ACCUM: begin
				in_ready  = 1'b1;
				cmd.accum = in_valid;
				if (in_valid && in_last) begin
					state_d = CS_FLUSH;
				end
			end
			CS_FLUSH: begin
				pc_d    = '0;
				state_d = CS_ISSUE;
			end
			CS_ISSUE: begin
				if (cond_ok) begin
					cmd.start_op = 1'b1;
					state_d      = CS_WAIT;
				end else if (last_step) begin
					state_d = CS_DONE;
				end else begin
					pc_d = pc_q + 1'b1;
				end
			end
			CS_WAIT: begin
				if (!stat.busy) begin
					if (last_step) begin
						state_d = CS_DONE;
					end else begin
						pc_d    = pc_q + 1'b1;
						state_d = CS_ISSUE;
					end
				end
			end
			CS_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = CS_ACCUM;
				end
			end
			default: begin
				state_d = CS_ACCUM;
			end
		endcase
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

>>> rtl/least_squares_line_fit_unit.sv
// Top level of the least-squares straight-line fit unit
// Usage:
//   samples: one transaction per (x_value, y_value) pair; last marks the final
//   pair of a data set. results: one transaction per data set, carrying the
//   Q16.16 means, slope and intercept, r squared in Q1.16 and a status code.
//   While a data set streams in, a pair is taken every cycle; each is
//   squared and multiplied in one stage and added to the running sums in the
//   next. After the last pair the block stops taking pairs and runs a
//   20-step solve program: up to 11 multiplies (one multiplier bit a cycle,
//   ending early) and 5 divides of BW bits on one shared serial unit, and
//   4 subtracts done directly; BW = 4*SAMPLE_BITS + 4*clog2(MAX_SAMPLES+1) + 20
//   (116 at the defaults).
//   Results sit in an output register: once loaded, the block clears its
//   sums and takes the next data set while the result waits. A stalled
//   receiver only holds up the next data set when its result is ready.
//   Pairs beyond MAX_SAMPLES are dropped and flagged with status 3.
//   Reset clears the sums, the count and all control; no result is pending.
`timescale 1ns / 1ps
`default_nettype none
`include "least_squares_line_fit_unit_macros.svh"
module least_squares_line_fit_unit #(
	parameter int MAX_SAMPLES = lsf_pkg::DEF_MAX_SAMPLES,
	parameter int SAMPLE_BITS = lsf_pkg::DEF_SAMPLE_BITS
) (
	input logic       clk,
	input logic       arst_n,
	lsf_in_if.sink    samples,
	lsf_out_if.source results
);
	import lsf_pkg::*;

	// command and status between sequencer and datapath
	cmd_t  cmd;
	stat_t stat;

	lsf_controller u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_last   (samples.last),
		.in_ready  (samples.ready),
		.out_ready (results.ready),
		.out_valid (results.valid),
		.cmd       (cmd),
		.stat      (stat)
	);

	lsf_datapath #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.x_value   (samples.x_value),
		.y_value   (samples.y_value),
		.cmd       (cmd),
		.stat      (stat),
		.mean_x    (results.mean_x),
		.mean_y    (results.mean_y),
		.slope     (results.slope),
		.intercept (results.intercept),
		.r_squared (results.r_squared),
		.status    (results.status)
	);

	// no pair is taken while the serial unit is working
	`LSF_ASSERT_SAME(a_no_accept_busy, clk, arst_n, stat.busy, !samples.ready)
	// never launch an operation over one still running
	`LSF_ASSERT_SAME(a_no_start_busy, clk, arst_n, cmd.start_op, !stat.busy)
	// a loaded result is offered in the following cycle
	`LSF_ASSERT_NEXT(a_load_valid, clk, arst_n, cmd.load_out, results.valid)
endmodule
`default_nettype wire
